// ===== src/md2_hash_engine_macros.svh =====
// Assertion helpers for the MD2 engine. Each expects i_clk and i_rst_n in scope.
`ifndef MD2_HASH_ENGINE_MACROS_SVH
`define MD2_HASH_ENGINE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define MD2_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("md2 check failed");

// Next-cycle implication, checked out of reset
`define MD2_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("md2 check failed");

`endif

// ===== src/md2_pkg.sv =====
package md2_pkg;

    localparam int unsigned MixBytes  = 48;
    localparam int unsigned BlkBytes  = 16;
    localparam int unsigned NumRounds = 18;

    localparam logic [7:0] SBOX [256] = '{
        8'd41,  8'd46,  8'd67,  8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
        8'd61,  8'd54,  8'd84,  8'd161, 8'd236, 8'd240, 8'd6,   8'd19,
        8'd98,  8'd167, 8'd5,   8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
        8'd152, 8'd147, 8'd43,  8'd217, 8'd188, 8'd76,  8'd130, 8'd202,
        8'd30,  8'd155, 8'd87,  8'd60,  8'd253, 8'd212, 8'd224, 8'd22,
        8'd103, 8'd66,  8'd111, 8'd24,  8'd138, 8'd23,  8'd229, 8'd18,
        8'd190, 8'd78,  8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
        8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47,  8'd238, 8'd122,
        8'd169, 8'd104, 8'd121, 8'd145, 8'd21,  8'd178, 8'd7,   8'd63,
        8'd148, 8'd194, 8'd16,  8'd137, 8'd11,  8'd34,  8'd95,  8'd33,
        8'd128, 8'd127, 8'd93,  8'd154, 8'd90,  8'd144, 8'd50,  8'd39,
        8'd53,  8'd62,  8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
        8'd255, 8'd25,  8'd48,  8'd179, 8'd72,  8'd165, 8'd181, 8'd209,
        8'd215, 8'd94,  8'd146, 8'd42,  8'd172, 8'd86,  8'd170, 8'd198,
        8'd79,  8'd184, 8'd56,  8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
        8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4,   8'd241,
        8'd69,  8'd157, 8'd112, 8'd89,  8'd100, 8'd113, 8'd135, 8'd32,
        8'd134, 8'd91,  8'd207, 8'd101, 8'd230, 8'd45,  8'd168, 8'd2,
        8'd27,  8'd96,  8'd37,  8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
        8'd28,  8'd70,  8'd97,  8'd105, 8'd52,  8'd64,  8'd126, 8'd15,
        8'd85,  8'd71,  8'd163, 8'd35,  8'd221, 8'd81,  8'd175, 8'd58,
        8'd195, 8'd92,  8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
        8'd44,  8'd83,  8'd13,  8'd110, 8'd133, 8'd40,  8'd132, 8'd9,
        8'd211, 8'd223, 8'd205, 8'd244, 8'd65,  8'd129, 8'd77,  8'd82,
        8'd106, 8'd220, 8'd55,  8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
        8'd36,  8'd225, 8'd123, 8'd8,   8'd12,  8'd189, 8'd177, 8'd74,
        8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99,  8'd232, 8'd109,
        8'd233, 8'd203, 8'd213, 8'd254, 8'd59,  8'd0,   8'd29,  8'd57,
        8'd242, 8'd239, 8'd183, 8'd14,  8'd102, 8'd88,  8'd208, 8'd228,
        8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75,  8'd10,
        8'd49,  8'd68,  8'd80,  8'd180, 8'd143, 8'd237, 8'd31,  8'd26,
        8'd219, 8'd153, 8'd141, 8'd51,  8'd159, 8'd17,  8'd131, 8'd20
    };

    function automatic logic [7:0] md2_sbox(input logic [7:0] idx);
        return SBOX[idx];
    endfunction

endpackage

// ===== src/md2_hash_engine.sv =====
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+------------------------------------------------
// input    | i_in_valid / o_in_ready     | i_block_low, i_block_high, i_valid_bytes, i_is_last
// output   | o_out_valid / i_out_ready   | o_digest_low, o_digest_high
//
// One S-box lookup per cycle while a block is at work: after acceptance a block is loaded,
// then runs 18 rounds over the 48-byte rotating state and 16 checksum steps.
// A last block adds one pass over the checksum, plus a whole pad block first when it is full.
// The 48-byte mix state and the 16-byte checksum are shift rings; the single S-box port
// sets the rate. Synchronous active-low reset clears state, checksum and handshakes.
// o_in_ready is low while a block is at work; a digest waits in its output register,
// and a finished digest holds the engine only if the previous one is still untaken.
`include "md2_hash_engine_macros.svh"

module md2_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_block_low,
    input  logic [63:0] i_block_high,
    input  logic [4:0]  i_valid_bytes,
    input  logic        i_is_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_digest_low,
    output logic [63:0] o_digest_high
);
    import md2_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MIX,
        S_SUM,
        S_CKLOAD,
        S_DONE
    } t_state;

    t_state      r_state, n_state;
    logic [7:0]  r_st  [MixBytes];
    logic [7:0]  n_st  [MixBytes];
    logic [7:0]  r_cs  [BlkBytes];
    logic [7:0]  n_cs  [BlkBytes];
    logic [7:0]  r_blk [BlkBytes];
    logic [7:0]  n_blk [BlkBytes];
    logic [7:0]  r_t, n_t;
    logic [5:0]  r_byte, n_byte;
    logic [4:0]  r_round, n_round;
    logic [3:0]  r_step, n_step;
    logic        r_pad_next, n_pad_next;
    logic        r_last, n_last;
    logic        r_final, n_final;
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_digest_low, n_digest_low;
    logic [63:0] r_digest_high, n_digest_high;

    logic [7:0]  sbox_idx;
    logic [7:0]  sbox_val;
    logic [7:0]  mix_new;
    logic [7:0]  sum_new;
    logic [4:0]  cnt_sat;
    logic [7:0]  pad_val;
    logic [7:0]  in_byte [BlkBytes];

    // Shared S-box: chained mix value, or checksum index while folding
    always_comb begin
        sbox_idx = (r_state == S_SUM) ? (r_blk[0] ^ r_cs[BlkBytes-1]) : r_t;
        sbox_val = md2_sbox(sbox_idx);
        mix_new  = r_st[0] ^ sbox_val;
        sum_new  = r_cs[0] ^ sbox_val;
    end

    // Pad the incoming block on a short last transaction
    always_comb begin
        cnt_sat = (i_valid_bytes > 5'd16) ? 5'd16 : i_valid_bytes;
        pad_val = {3'b000, 5'd16 - cnt_sat};
        for (int i = 0; i < 8; i++) begin
            in_byte[i]     = i_block_low[8*i +: 8];
            in_byte[8 + i] = i_block_high[8*i +: 8];
        end
        for (int i = 0; i < BlkBytes; i++) begin
            if (i_is_last && (cnt_sat != 5'd16) && (5'(i) >= cnt_sat)) begin
                in_byte[i] = pad_val;
            end
        end
    end

    // Sequencer
    always_comb begin
        n_state       = r_state;
        n_st          = r_st;
        n_cs          = r_cs;
        n_blk         = r_blk;
        n_t           = r_t;
        n_byte        = r_byte;
        n_round       = r_round;
        n_step        = r_step;
        n_pad_next    = r_pad_next;
        n_last        = r_last;
        n_final       = r_final;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_digest_low  = r_digest_low;
        n_digest_high = r_digest_high;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_blk      = in_byte;
                    n_last     = i_is_last;
                    n_pad_next = i_is_last && (cnt_sat == 5'd16);
                    n_final    = 1'b0;
                    n_state    = S_LOAD;
                end
            end
            S_LOAD: begin
                for (int i = 0; i < BlkBytes; i++) begin
                    n_st[BlkBytes + i]   = r_blk[i];
                    n_st[2*BlkBytes + i] = r_st[i] ^ r_blk[i];
                end
                n_t     = '0;
                n_byte  = '0;
                n_round = '0;
                n_state = S_MIX;
            end
            S_MIX: begin
                // rotate the state ring, new byte enters at the tail
                for (int i = 0; i < MixBytes - 1; i++) begin
                    n_st[i] = r_st[i + 1];
                end
                n_st[MixBytes-1] = mix_new;
                n_t = mix_new;
                if (r_byte == 6'(MixBytes - 1)) begin
                    n_byte = '0;
                    n_t    = mix_new + {3'b000, r_round};
                    if (r_round == 5'(NumRounds - 1)) begin
                        n_step  = '0;
                        n_state = r_final ? S_DONE : S_SUM;
                    end else begin
                        n_round = r_round + 5'd1;
                    end
                end else begin
                    n_byte = r_byte + 6'd1;
                end
            end
            S_SUM: begin
                // fold one block byte into the checksum ring
                for (int i = 0; i < BlkBytes - 1; i++) begin
                    n_cs[i]  = r_cs[i + 1];
                    n_blk[i] = r_blk[i + 1];
                end
                n_cs[BlkBytes-1]  = sum_new;
                n_blk[BlkBytes-1] = r_blk[0];
                n_step = r_step + 4'd1;
                if (r_step == 4'(BlkBytes - 1)) begin
                    if (r_pad_next) begin
                        for (int i = 0; i < BlkBytes; i++) begin
                            n_blk[i] = 8'd16;
                        end
                        n_pad_next = 1'b0;
                        n_state    = S_LOAD;
                    end else if (r_last) begin
                        n_state = S_CKLOAD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_CKLOAD: begin
                n_blk   = r_cs;
                n_final = 1'b1;
                n_state = S_LOAD;
            end
            S_DONE: begin
                // hand off the digest once the output register is free, then clear
                if (!r_out_valid || i_out_ready) begin
                    for (int i = 0; i < 8; i++) begin
                        n_digest_low[8*i +: 8]  = r_st[i];
                        n_digest_high[8*i +: 8] = r_st[8 + i];
                    end
                    n_out_valid = 1'b1;
                    for (int i = 0; i < MixBytes; i++) begin
                        n_st[i] = '0;
                    end
                    for (int i = 0; i < BlkBytes; i++) begin
                        n_cs[i] = '0;
                    end
                    n_last  = 1'b0;
                    n_final = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            for (int i = 0; i < MixBytes; i++) begin
                r_st[i] <= '0;
            end
            for (int i = 0; i < BlkBytes; i++) begin
                r_cs[i] <= '0;
            end
            r_t         <= '0;
            r_byte      <= '0;
            r_round     <= '0;
            r_step      <= '0;
            r_pad_next  <= 1'b0;
            r_last      <= 1'b0;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_st        <= n_st;
            r_cs        <= n_cs;
            r_t         <= n_t;
            r_byte      <= n_byte;
            r_round     <= n_round;
            r_step      <= n_step;
            r_pad_next  <= n_pad_next;
            r_last      <= n_last;
            r_final     <= n_final;
            r_out_valid <= n_out_valid;
        end
        r_blk         <= n_blk;
        r_digest_low  <= n_digest_low;
        r_digest_high <= n_digest_high;
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_digest_low  = r_digest_low;
    assign o_digest_high = r_digest_high;

    // Checks
    `MD2_ASSERT_NEXT(a_accept_loads, i_in_valid && o_in_ready, r_state == S_LOAD)
    `MD2_ASSERT_NOW(a_digest_from_done, $rose(r_out_valid), $past(r_state) == S_DONE)
    `MD2_ASSERT_NEXT(a_digest_held, r_out_valid && !i_out_ready, r_out_valid && $stable(r_digest_low) && $stable(r_digest_high))
    `MD2_ASSERT_NOW(a_counters_range, 1'b1, (r_byte <= 6'(MixBytes - 1)) && (r_round <= 5'(NumRounds - 1)))
    `MD2_ASSERT_NOW(a_cleared_after_digest, $rose(r_out_valid), (r_st[0] == 8'd0) && (r_cs[BlkBytes-1] == 8'd0) && !r_final)

endmodule

// ===== verif/md2_digest_checker.sv =====
module md2_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [63:0] i_block_low,
    input  logic [63:0] i_block_high,
    input  logic [4:0]  i_valid_bytes,
    input  logic        i_is_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [63:0] i_digest_low,
    input  logic [63:0] i_digest_high,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_digests
);
    import md2_pkg::*;

    typedef logic [7:0] t_block_bytes [BlkBytes];

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
    } t_digest;

    // Shadow copy of the engine's mixing state and running checksum
    logic [7:0] mix_bytes [MixBytes];
    logic [7:0] sum_bytes [BlkBytes];
    t_digest    awaited_digests [$];

    function automatic void clear_state();
        foreach (mix_bytes[i]) mix_bytes[i] = 8'd0;
        foreach (sum_bytes[i]) sum_bytes[i] = 8'd0;
    endfunction

    // Load a block into the state and run the 18 S-box rounds
    function automatic void mix_in(input t_block_bytes blk);
        logic [7:0] t;
        t = 8'd0;
        for (int i = 0; i < BlkBytes; i++) begin
            mix_bytes[BlkBytes + i]   = blk[i];
            mix_bytes[2*BlkBytes + i] = mix_bytes[i] ^ blk[i];
        end
        for (int r = 0; r < NumRounds; r++) begin
            for (int i = 0; i < MixBytes; i++) begin
                mix_bytes[i] = mix_bytes[i] ^ SBOX[t];
                t = mix_bytes[i];
            end
            t = t + 8'(r);
        end
    endfunction

    // Chain the block through the checksum, seeded by the checksum's last byte
    function automatic void fold_sum(input t_block_bytes blk);
        logic [7:0] prev;
        prev = sum_bytes[BlkBytes-1];
        for (int i = 0; i < BlkBytes; i++) begin
            sum_bytes[i] = sum_bytes[i] ^ SBOX[blk[i] ^ prev];
            prev = sum_bytes[i];
        end
    endfunction

    function automatic void absorb(input t_block_bytes blk);
        mix_in(blk);
        fold_sum(blk);
    endfunction

    // Advance the shadow state by one accepted block; queue a digest on a last block
    function automatic void hash_block(input logic [63:0] lo, input logic [63:0] hi,
                                       input logic [4:0] cnt, input logic last);
        t_block_bytes blk;
        int           n;
        t_digest      d;
        for (int i = 0; i < 8; i++) begin
            blk[i]     = lo[8*i +: 8];
            blk[8 + i] = hi[8*i +: 8];
        end
        if (!last) begin
            absorb(blk);
            return;
        end
        // Saturate the count; a full last block is followed by a whole pad block
        n = (cnt > 5'd16) ? 16 : int'(cnt);
        if (n == 16) begin
            absorb(blk);
            n = 0;
        end
        for (int i = n; i < BlkBytes; i++) blk[i] = 8'(16 - n);
        absorb(blk);
        mix_in(sum_bytes);
        for (int i = 0; i < 8; i++) begin
            d.lo[8*i +: 8] = mix_bytes[i];
            d.hi[8*i +: 8] = mix_bytes[8 + i];
        end
        awaited_digests.push_back(d);
        clear_state();
    endfunction

    function automatic void report_field(input string name, input logic [63:0] want,
                                         input logic [63:0] got);
        if (got !== want) begin
            o_mismatches++;
            if (o_mismatches <= 10)
                $display("digest %0d %s: expected %h, got %h", o_digests, name, want, got);
        end
    endfunction

    // Compare a taken digest against the oldest prediction
    function automatic void check_digest();
        t_digest want;
        o_digests++;
        if (awaited_digests.size() == 0) begin
            o_mismatches++;
            if (o_mismatches <= 10)
                $display("digest %0d: unexpected, got %h %h", o_digests,
                         i_digest_high, i_digest_low);
            return;
        end
        want = awaited_digests.pop_front();
        report_field("low", want.lo, i_digest_low);
        report_field("high", want.hi, i_digest_high);
    endfunction

    // Watch both channels on the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
            awaited_digests.delete();
            o_mismatches = 0;
            o_digests    = 0;
        end else begin
            if (i_in_valid && i_in_ready)
                hash_block(i_block_low, i_block_high, i_valid_bytes, i_is_last);
            if (i_out_valid && i_out_ready)
                check_digest();
        end
        o_pending = awaited_digests.size();
    end

endmodule

// ===== verif/testbench.sv =====
module testbench;

    localparam int NumItems = 680;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_HOLD,
        RX_SPARSE
    } t_rx_mode;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] block_low;
    logic [63:0] block_high;
    logic [4:0]  valid_bytes;
    logic        is_last;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] digest_low;
    logic [63:0] digest_high;

    int mismatches;
    int pending;
    int digests;

    int blocks_sent = 0;
    int msgs_sent   = 0;
    int full_lasts  = 0;
    int over_lasts  = 0;
    int short_lasts = 0;
    int burst_left  = 1;

    t_rx_mode rx_mode    = RX_OPEN;
    int       rx_left    = 0;

    always #4 clk = ~clk;

    md2_hash_engine u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_block_low   (block_low),
        .i_block_high  (block_high),
        .i_valid_bytes (valid_bytes),
        .i_is_last     (is_last),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_digest_low  (digest_low),
        .o_digest_high (digest_high)
    );

    md2_digest_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_block_low   (block_low),
        .i_block_high  (block_high),
        .i_valid_bytes (valid_bytes),
        .i_is_last     (is_last),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_digest_low  (digest_low),
        .i_digest_high (digest_high),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_digests     (digests)
    );

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Hold one block on the input until the transaction completes, then maybe idle
    task automatic send_block(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] cnt, input logic last);
        int gap;
        in_valid    = 1'b1;
        block_low   = lo;
        block_high  = hi;
        valid_bytes = cnt;
        is_last     = last;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        blocks_sent++;
        if (last) begin
            msgs_sent++;
            if (cnt == 5'd16)
                full_lasts++;
            else if (cnt > 5'd16)
                over_lasts++;
            else
                short_lasts++;
        end
        burst_left--;
        if (burst_left <= 0) begin
            in_valid = 1'b0;
            gap = ($urandom_range(15, 0) == 0) ? $urandom_range(1200, 1)
                                                : $urandom_range(20, 1);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(7, 0) == 0) ? 40 : $urandom_range(8, 1);
        end
    endtask

    // Random content for every block; last count mostly short, sometimes full or over
    task automatic send_message(input int nblocks);
        int          pick;
        logic [4:0]  cnt;
        pick = $urandom_range(9, 0);
        if (pick < 6)
            cnt = 5'($urandom_range(15, 0));
        else if (pick < 8)
            cnt = 5'd16;
        else
            cnt = 5'($urandom_range(31, 17));
        for (int k = 0; k < nblocks - 1; k++)
            send_block(rand_word(), rand_word(), 5'($urandom_range(31, 0)), 1'b0);
        send_block(rand_word(), rand_word(), cnt, 1'b1);
    endtask

    // Receiver: stretches of always ready, coin flips, full holds and sparse stalls
    always @(negedge clk) begin
        if (rx_left <= 0) begin
            rx_mode = t_rx_mode'($urandom_range(3, 0));
            rx_left = (rx_mode == RX_HOLD) ? $urandom_range(3000, 1)
                                           : $urandom_range(4000, 1);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   out_ready <= 1'b1;
            RX_COIN:   out_ready <= 1'($urandom_range(1, 0));
            RX_HOLD:   out_ready <= 1'b0;
            RX_SPARSE: out_ready <= ($urandom_range(7, 0) != 0);
            default:   out_ready <= 1'b1;
        endcase
    end

    initial begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        block_low   = '0;
        block_high  = '0;
        valid_bytes = '0;
        is_last     = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty message and a short ASCII message
        send_block(64'h0, 64'h0, 5'd0, 1'b1);
        send_block(64'h0000_0000_0063_6261, 64'h0, 5'd3, 1'b1);
        // Full last blocks, then counts above sixteen
        send_block('1, '1, 5'd16, 1'b1);
        send_block(64'h0, 64'h0, 5'd16, 1'b1);
        send_block('1, '1, 5'd31, 1'b1);
        send_block(64'h0, '1, 5'd17, 1'b1);
        // Edge counts, garbage past the count
        send_block(64'h0, 64'h0, 5'd1, 1'b1);
        send_block('1, '1, 5'd15, 1'b1);
        send_block('1, '1, 5'd8, 1'b1);
        // Multi-block messages with ignored counts on inner blocks
        send_block('1, '1, 5'd0, 1'b0);
        send_block(64'h0, 64'h0, 5'd31, 1'b0);
        send_block('1, '1, 5'd5, 1'b1);
        send_block('1, 64'h0, 5'd16, 1'b0);
        send_block(64'h0, '1, 5'd0, 1'b1);
        send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 5'd7, 1'b0);
        send_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 5'd16, 1'b1);

        // Random messages of one to six blocks
        while (blocks_sent < NumItems)
            send_message($urandom_range(6, 1));

        // Drain outstanding digests
        in_valid = 1'b0;
        wait (pending == 0);
        repeat (2000) @(posedge clk);

        $display("Sent %0d blocks in %0d messages: %0d short, %0d full, %0d over-count last",
                 blocks_sent, msgs_sent, short_lasts, full_lasts, over_lasts);
        $display("Checked %0d digests with random input gaps and output stalls", digests);
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #150_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/md2_pkg.sv
src/md2_hash_engine.sv
verif/md2_digest_checker.sv
verif/testbench.sv
